@@ src/mucw_pkg.sv @@
package mucw_pkg;

	// Field widths fixed by the item formats
	localparam int VTX_W     = 4;
	localparam int CYC_W     = 3;
	localparam int POS_W     = 4;
	// Most results one run may produce
	localparam int RESULT_CAP = 16;
	localparam int RES_CNT_W  = $clog2(RESULT_CAP + 1);

	// One load transaction
	typedef struct packed {
		logic [VTX_W-1:0] vertex;
		logic [VTX_W-1:0] partner_first;
		logic [VTX_W-1:0] partner_second;
		logic             load_done;
	} item_t;

	// One emitted vertex of the walk
	typedef struct packed {
		logic [VTX_W-1:0] cycle_vertex;
		logic [CYC_W-1:0] cycle_number;
		logic [POS_W-1:0] cycle_position;
		logic             cycle_end;
		logic             run_end;
		logic             malformed;
	} result_t;

	// Classified command handed from front to back
	typedef struct packed {
		logic [VTX_W-1:0] vertex;
		logic [VTX_W-1:0] partner_first;
		logic [VTX_W-1:0] partner_second;
		logic             wr_en;
		logic             walk;
	} cmd_t;

	// Back-end sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIND,
		ST_STEP_A,
		ST_STEP_B,
		ST_FINISH
	} walk_st_t;

endpackage

@@ src/matching_union_cycle_walk_core.sv @@
// Matching union cycle walk.
// Input channel: drive item with start high; the transaction is taken at a
// rising edge where start is high and busy is low. Each transaction loads the
// first and second partner of one vertex; the one with load_done set also
// starts a decomposition of the union of both matchings into cycles.
// Result channel: result_valid is high for exactly one cycle per emitted
// vertex and result is taken at the edge that ends it; there is no stall.
// Load transactions go through a staging register and a two-entry queue, so
// one is taken every cycle while the walker is idle. A walk emits at most one
// result per cycle, with an extra step at each cycle start, the pop and the
// finish, paced by the registered read ports of the partner tables. The first
// result passes the staging register, the queue, FIND, then STEP_A (FINISH if
// the walk stops on its first vertex) and the output register. busy is high
// while the staging register is occupied and the queue is full.
// Reset clears control state and the visited marks; the partner tables are
// undefined until written.
module matching_union_cycle_walk_core
	import mucw_pkg::*;
#(
	parameter int VERTEX_COUNT = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output result_t result,
	output logic    result_valid
);

	cmd_t fe_cmd;
	logic fe_push;
	logic q_full;
	cmd_t q_cmd;
	logic q_valid;
	logic q_pop;

	mucw_front #(.VERTEX_COUNT(VERTEX_COUNT)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.cmd      (fe_cmd),
		.cmd_push (fe_push),
		.q_full   (q_full)
	);

	mucw_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_data (fe_cmd),
		.push      (fe_push),
		.full      (q_full),
		.pop_data  (q_cmd),
		.pop_valid (q_valid),
		.pop       (q_pop)
	);

	mucw_back #(.VERTEX_COUNT(VERTEX_COUNT)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (q_cmd),
		.cmd_valid    (q_valid),
		.cmd_pop      (q_pop),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule

@@ src/mucw_ram.sv @@
module mucw_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ src/mucw_front.sv @@
module mucw_front
	import mucw_pkg::*;
#(
	parameter int VERTEX_COUNT = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	output logic  busy,
	input  item_t item,
	output cmd_t  cmd,
	output logic  cmd_push,
	input  logic  q_full
);

	logic fe_v_q;
	cmd_t fe_q;
	logic accept;

	assign busy     = fe_v_q && q_full;
	assign accept   = start && !busy;
	assign cmd_push = fe_v_q && !q_full;
	assign cmd      = fe_q;

	// Staging register: classify the transaction on the way in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fe_v_q <= 1'b0;
		end else if (accept) begin
			fe_v_q <= 1'b1;
		end else if (cmd_push) begin
			fe_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fe_q.vertex         <= item.vertex;
			fe_q.partner_first  <= item.partner_first;
			fe_q.partner_second <= item.partner_second;
			// out-of-range vertex is dropped, the walk still runs
			fe_q.wr_en          <= (int'(item.vertex) < VERTEX_COUNT);
			fe_q.walk           <= item.load_done;
		end
	end

endmodule

@@ src/mucw_fifo.sv @@
module mucw_fifo
	import mucw_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  cmd_t push_data,
	input  logic push,
	output logic full,
	output cmd_t pop_data,
	output logic pop_valid,
	input  logic pop
);

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_data  = slot_q[rd_ptr_q];

	// Two-entry queue between front and back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop && pop_valid) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push && !full, pop && pop_valid})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ src/mucw_back.sv @@
module mucw_back
	import mucw_pkg::*;
#(
	parameter int VERTEX_COUNT = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    cmd,
	input  logic    cmd_valid,
	output logic    cmd_pop,
	output result_t result,
	output logic    result_valid
);

	localparam int VW = $clog2(VERTEX_COUNT);
	localparam int XW = (VW > VTX_W) ? VW : VTX_W;
	localparam int CW = XW + 1;

	walk_st_t state_q, state_d;

	logic [VERTEX_COUNT-1:0] visited_q;
	logic [VW-1:0]           start_q;
	logic [CYC_W-1:0]        cyc_q;
	logic [RES_CNT_W-1:0]    pos_q;
	logic [RES_CNT_W-1:0]    n_q;
	logic                    bad_q;
	result_t                 pend_q;
	logic                    pend_v_q;
	result_t                 out_q;
	logic                    strobe_q;

	logic [VTX_W-1:0] first_rd, second_rd;
	logic [XW-1:0]    wr_ext;
	logic             ram_we;

	logic             found;
	logic [VW-1:0]    found_idx;
	logic [VTX_W-1:0] nxt_raw;
	logic [XW-1:0]    nxt_ext;
	logic [VW-1:0]    nxt_idx;
	logic             nxt_oob;
	logic             n_full;
	logic             pos_over;

	logic                 emit;
	logic [VW-1:0]        emit_idx;
	logic [RES_CNT_W-1:0] emit_pos;
	logic [XW-1:0]        emit_ext;
	logic                 go_bad;
	logic                 go_close;
	logic                 go_fin;

	assign cmd_pop      = (state_q == ST_IDLE) && cmd_valid;
	assign result       = out_q;
	assign result_valid = strobe_q;

	// Partner tables, written together at pop, read at the emitted vertex
	assign ram_we = cmd_pop && cmd.wr_en;
	assign wr_ext = XW'(cmd.vertex);

	mucw_ram #(.WIDTH(VTX_W), .DEPTH(VERTEX_COUNT)) u_first_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_ext[VW-1:0]),
		.wdata (cmd.partner_first),
		.raddr (emit_idx),
		.rdata (first_rd)
	);

	mucw_ram #(.WIDTH(VTX_W), .DEPTH(VERTEX_COUNT)) u_second_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_ext[VW-1:0]),
		.wdata (cmd.partner_second),
		.raddr (emit_idx),
		.rdata (second_rd)
	);

	// Lowest unvisited vertex
	always_comb begin
		found     = 1'b0;
		found_idx = '0;
		for (int i = VERTEX_COUNT - 1; i >= 0; i--) begin
			if (!visited_q[i]) begin
				found     = 1'b1;
				found_idx = VW'(i);
			end
		end
	end

	// Partner just read back
	assign nxt_raw  = (state_q == ST_STEP_A) ? first_rd : second_rd;
	assign nxt_ext  = XW'(nxt_raw);
	assign nxt_idx  = nxt_ext[VW-1:0];
	assign nxt_oob  = (CW'(nxt_raw) >= CW'(VERTEX_COUNT));
	assign n_full   = (n_q >= RES_CNT_W'(RESULT_CAP));
	assign pos_over = (int'(pos_q) >= VERTEX_COUNT);
	assign emit_ext = XW'(emit_idx);

	// Step decisions
	always_comb begin
		emit     = 1'b0;
		emit_idx = '0;
		emit_pos = pos_q;
		go_bad   = 1'b0;
		go_close = 1'b0;
		go_fin   = 1'b0;
		case (state_q)
			ST_FIND: begin
				emit_idx = found_idx;
				emit_pos = '0;
				if (!found) begin
					go_fin = 1'b1;
				end else if (n_full) begin
					go_bad = 1'b1;
				end else begin
					emit = 1'b1;
				end
			end
			ST_STEP_A: begin
				emit_idx = nxt_idx;
				if (nxt_oob || n_full) begin
					go_bad = 1'b1;
				end else begin
					emit = 1'b1;
				end
			end
			ST_STEP_B: begin
				emit_idx = nxt_idx;
				if (nxt_oob) begin
					go_bad = 1'b1;
				end else if (nxt_idx == start_q) begin
					go_close = 1'b1;
				end else if (pos_over || n_full) begin
					go_bad = 1'b1;
				end else begin
					emit = 1'b1;
				end
			end
			default: begin
				emit_idx = '0;
			end
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_pop && cmd.walk) begin
					state_d = ST_FIND;
				end
			end
			ST_FIND: begin
				if (emit) begin
					state_d = ST_STEP_A;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_STEP_A: begin
				if (emit) begin
					state_d = ST_STEP_B;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_STEP_B: begin
				if (emit) begin
					state_d = ST_STEP_A;
				end else if (go_close) begin
					state_d = ST_FIND;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Control state: FSM, marks, counters, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			visited_q <= '0;
			start_q   <= '0;
			cyc_q     <= '0;
			pos_q     <= '0;
			n_q       <= '0;
			bad_q     <= 1'b0;
			pend_v_q  <= 1'b0;
			strobe_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			// held result goes out on the next emit or at finish
			strobe_q <= pend_v_q && (emit || (state_q == ST_FINISH));
			if (cmd_pop && cmd.walk) begin
				visited_q <= '0;
				cyc_q     <= '0;
				pos_q     <= '0;
				n_q       <= '0;
				bad_q     <= 1'b0;
				pend_v_q  <= 1'b0;
			end
			if (emit) begin
				visited_q[emit_idx] <= 1'b1;
				pos_q               <= emit_pos + RES_CNT_W'(1);
				n_q                 <= n_q + RES_CNT_W'(1);
				pend_v_q            <= 1'b1;
				if (state_q == ST_FIND) begin
					start_q <= found_idx;
				end
			end
			if (go_close) begin
				cyc_q <= cyc_q + CYC_W'(1);
			end
			if (go_bad) begin
				bad_q <= 1'b1;
			end
			if (state_q == ST_FINISH) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	// Held result and output register
	always_ff @(posedge clk) begin
		if (emit) begin
			out_q                 <= pend_q;
			pend_q.cycle_vertex   <= emit_ext[VTX_W-1:0];
			pend_q.cycle_number   <= cyc_q;
			pend_q.cycle_position <= emit_pos[POS_W-1:0];
			pend_q.cycle_end      <= 1'b0;
			pend_q.run_end        <= 1'b0;
			pend_q.malformed      <= 1'b0;
		end
		if (go_close) begin
			pend_q.cycle_end <= 1'b1;
		end
		if (state_q == ST_FINISH) begin
			out_q.cycle_vertex   <= pend_q.cycle_vertex;
			out_q.cycle_number   <= pend_q.cycle_number;
			out_q.cycle_position <= pend_q.cycle_position;
			out_q.run_end        <= 1'b1;
			out_q.malformed      <= bad_q;
			out_q.cycle_end      <= pend_q.cycle_end && !bad_q;
		end
	end

	a_malformed_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.malformed) |-> (result.run_end && !result.cycle_end))
		else $error("malformed result without run end");

	a_gap_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.run_end) |=> !result_valid)
		else $error("result right after run end");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= RES_CNT_W'(RESULT_CAP))
		else $error("result count over cap");

	a_idle_no_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_v_q)
		else $error("held result left over in idle");

endmodule

@@ verif/tb_matching_union_cycle_walk_core.sv @@
module tb_matching_union_cycle_walk_core;
	import mucw_pkg::*;

	localparam int VERTEX_COUNT   = 16;
	localparam int TARGET_ITEMS   = 260;
	// No idle bursts once the pending queue drops to this or below
	localparam int CALM_TAIL      = 48;
	// Walk over all 16 vertices plus pipeline, with margin
	localparam int DRAIN_CYCLES   = 64;
	localparam int WATCHDOG_LIMIT = 2000;

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	logic    busy;
	item_t   load_item = '0;
	result_t walk_result;
	logic    result_valid;

	matching_union_cycle_walk_core #(
		.VERTEX_COUNT(VERTEX_COUNT)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.item        (load_item),
		.result      (walk_result),
		.result_valid(result_valid)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	item_t   pending_items [$];
	result_t walk_expect [$];
	int      mismatches   = 0;
	int      gap_cycles   = 0;
	int      quiet_cycles = 0;

	// Predicted block state
	logic [VTX_W-1:0]        first_tbl  [VERTEX_COUNT];
	logic [VTX_W-1:0]        second_tbl [VERTEX_COUNT];
	logic [VERTEX_COUNT-1:0] visited = '0;
	logic [CYC_W-1:0]        cycle_idx = '0;
	logic [POS_W-1:0]        position_idx = '0;

	// Stimulus planning: intended matchings and a scratch vertex order
	int plan_first  [VERTEX_COUNT];
	int plan_second [VERTEX_COUNT];
	int order       [VERTEX_COUNT];

	function automatic result_t vertex_result(input int v);
		result_t r;
		r = '0;
		r.cycle_vertex   = v[VTX_W-1:0];
		r.cycle_number   = cycle_idx;
		r.cycle_position = position_idx;
		return r;
	endfunction

	// Store one load transaction; on load_done decompose the union into cycles
	task automatic predict_load(input item_t it);
		result_t run_res [RESULT_CAP];
		int n, cur, nxt, pos;
		bit bad;
		if (int'(it.vertex) < VERTEX_COUNT) begin
			first_tbl[it.vertex]  = it.partner_first;
			second_tbl[it.vertex] = it.partner_second;
		end
		if (!it.load_done)
			return;
		visited      = '0;
		cycle_idx    = '0;
		position_idx = '0;
		n   = 0;
		bad = 1'b0;
		for (int root = 0; root < VERTEX_COUNT && !bad; root++) begin
			if (visited[root])
				continue;
			cur = root;
			pos = 0;
			forever begin
				if (n >= RESULT_CAP) begin
					bad = 1'b1;
					break;
				end
				// current vertex, then step along the first matching
				position_idx = pos[POS_W-1:0];
				visited[cur] = 1'b1;
				run_res[n]   = vertex_result(cur);
				n++;
				pos++;
				nxt = int'(first_tbl[cur]);
				if (nxt >= VERTEX_COUNT || n >= RESULT_CAP) begin
					bad = 1'b1;
					break;
				end
				cur = nxt;
				// first partner, then step along the second matching
				position_idx = pos[POS_W-1:0];
				visited[cur] = 1'b1;
				run_res[n]   = vertex_result(cur);
				n++;
				pos++;
				nxt = int'(second_tbl[cur]);
				if (nxt >= VERTEX_COUNT) begin
					bad = 1'b1;
					break;
				end
				cur = nxt;
				if (cur == root) begin
					run_res[n-1].cycle_end = 1'b1;
					break;
				end
				if (pos >= VERTEX_COUNT) begin
					bad = 1'b1;
					break;
				end
			end
			if (!bad)
				cycle_idx = cycle_idx + 1'b1;
		end
		if (n > 0) begin
			run_res[n-1].run_end = 1'b1;
			if (bad) begin
				run_res[n-1].cycle_end = 1'b0;
				run_res[n-1].malformed = 1'b1;
			end
		end
		for (int k = 0; k < n; k++)
			walk_expect = {walk_expect, run_res[k]};
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Stimulus helpers
	task automatic queue_item(input int v, input int pf, input int ps, input bit done);
		item_t it;
		it.vertex         = v[VTX_W-1:0];
		it.partner_first  = pf[VTX_W-1:0];
		it.partner_second = ps[VTX_W-1:0];
		it.load_done      = done;
		pending_items = {pending_items, it};
	endtask

	task automatic shuffle_order();
		int j, t;
		for (int i = 0; i < VERTEX_COUNT; i++)
			order[i] = i;
		for (int i = VERTEX_COUNT - 1; i > 0; i--) begin
			j = $urandom_range(i, 0);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
	endtask

	// Pair neighbors in the current order, rotated by shift
	task automatic pair_order(input bit to_second, input int shift);
		int a, b;
		for (int k = 0; k < VERTEX_COUNT; k += 2) begin
			a = order[(k + shift) % VERTEX_COUNT];
			b = order[(k + 1 + shift) % VERTEX_COUNT];
			if (to_second) begin
				plan_second[a] = b;
				plan_second[b] = a;
			end else begin
				plan_first[a] = b;
				plan_first[b] = a;
			end
		end
	endtask

	// Reload every vertex in random order; optionally break one first partner
	task automatic queue_full_plan(input int corrupt_at);
		int v, pf;
		shuffle_order();
		for (int i = 0; i < VERTEX_COUNT; i++) begin
			v  = order[i];
			pf = plan_first[v];
			if (i == corrupt_at)
				pf = $urandom_range(VERTEX_COUNT - 1, 0);
			queue_item(v, pf, plan_second[v], i == VERTEX_COUNT - 1);
		end
	endtask

	// Cross-link the edges at a and c in one matching and reload a, b, c and d
	task automatic swap_pairs(input bit in_second);
		int a, b, c, d;
		a = $urandom_range(VERTEX_COUNT - 1, 0);
		b = in_second ? plan_second[a] : plan_first[a];
		do
			c = $urandom_range(VERTEX_COUNT - 1, 0);
		while (c == a || c == b);
		d = in_second ? plan_second[c] : plan_first[c];
		if (in_second) begin
			plan_second[a] = c; plan_second[c] = a;
			plan_second[b] = d; plan_second[d] = b;
		end else begin
			plan_first[a] = c; plan_first[c] = a;
			plan_first[b] = d; plan_first[d] = b;
		end
		queue_item(a, plan_first[a], plan_second[a], 1'b0);
		queue_item(b, plan_first[b], plan_second[b], 1'b0);
		queue_item(c, plan_first[c], plan_second[c], 1'b0);
		queue_item(d, plan_first[d], plan_second[d], 1'b1);
	endtask

	// Driver: present pending transactions, idle in random bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy)
				predict_load(load_item);
			if (start && busy) begin
				// hold until taken
			end else if (gap_cycles != 0) begin
				gap_cycles <= gap_cycles - 1;
				start <= 1'b0;
			end else if (pending_items.size() > CALM_TAIL && $urandom_range(5, 0) == 0) begin
				gap_cycles <= $urandom_range(6, 0);
				start <= 1'b0;
			end else if (pending_items.size() != 0) begin
				start     <= 1'b1;
				load_item <= pending_items.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: compare each emitted vertex with the oldest prediction
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid) begin
			if (walk_expect.size() == 0) begin
				$error("result with nothing pending: cycle_vertex %0d", walk_result.cycle_vertex);
				mismatches++;
			end else begin
				want = walk_expect.pop_front();
				check_field("cycle_vertex", want.cycle_vertex, walk_result.cycle_vertex);
				check_field("cycle_number", want.cycle_number, walk_result.cycle_number);
				check_field("cycle_position", want.cycle_position,
					walk_result.cycle_position);
				check_field("cycle_end", want.cycle_end, walk_result.cycle_end);
				check_field("run_end", want.run_end, walk_result.run_end);
				check_field("malformed", want.malformed, walk_result.malformed);
			end
		end
	end

	// Watchdog on cycles with no transaction either way
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("matching_union_cycle_walk_core: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int pick, n;
		for (int v = 0; v < VERTEX_COUNT; v++) begin
			first_tbl[v]   = '0;
			second_tbl[v]  = '0;
			plan_first[v]  = v ^ 1;
			plan_second[v] = v ^ 1;
		end

		// Both matchings equal: eight two-vertex cycles, every cycle index used
		for (int v = 0; v < VERTEX_COUNT; v++)
			queue_item(v, v ^ 1, v ^ 1, v == VERTEX_COUNT - 1);
		// Walk from 0 falls into the 2-3 loop and never closes
		queue_item(1, 0, 2, 1'b1);
		// Self partner on 0: first cycle closes, next one spins until the result cap
		queue_item(1, 0, 0, 1'b0);
		queue_item(0, 0, 0, 1'b1);
		// Restore the matchings and walk clean again
		queue_item(0, 1, 1, 1'b1);

		// Random part: mostly well-formed matchings, some broken sets and noise
		while (pending_items.size() < TARGET_ITEMS) begin
			pick = $urandom_range(99, 0);
			if (pick < 25) begin
				shuffle_order();
				pair_order(1'b0, 0);
				shuffle_order();
				pair_order(1'b1, 0);
				queue_full_plan(-1);
			end else if (pick < 40) begin
				// one cycle through all vertices
				shuffle_order();
				pair_order(1'b0, 0);
				pair_order(1'b1, 1);
				queue_full_plan(-1);
			end else if (pick < 48) begin
				shuffle_order();
				pair_order(1'b0, 0);
				pair_order(1'b1, 0);
				queue_full_plan(-1);
			end else if (pick < 70) begin
				swap_pairs($urandom_range(1, 0));
			end else if (pick < 85) begin
				queue_full_plan($urandom_range(VERTEX_COUNT - 1, 0));
			end else begin
				n = $urandom_range(4, 1);
				for (int i = 0; i < n; i++)
					queue_item($urandom_range(VERTEX_COUNT - 1, 0),
						$urandom_range(VERTEX_COUNT - 1, 0),
						$urandom_range(VERTEX_COUNT - 1, 0),
						(i == n - 1) ? $urandom_range(1, 0) : 0);
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || start)
			@(posedge clk);
		while (walk_expect.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("matching_union_cycle_walk_core: match");
		else
			$display("matching_union_cycle_walk_core: mismatch");
		$finish;
	end

endmodule
